// ----- hdl/vsrf_pkg.sv -----
// Package: types, register map and power-up palette of the video shifter register file.
`timescale 1ns / 1ps

package vsrf_pkg;

    typedef logic [6:0]  t_ofs;
    typedef logic [15:0] t_colour;
    typedef logic [1:0]  t_rez;

    typedef enum logic [1:0] {
        OP_READ   = 2'd0,
        OP_WRITE  = 2'd1,
        OP_REINIT = 2'd2
    } t_op;

    typedef enum logic {
        CFG_SCREEN_START = 1'b0,
        CFG_PLANE_COUNT  = 1'b1
    } t_cfg_index;

    localparam t_ofs OFS_BASE_HI   = 7'h01;
    localparam t_ofs OFS_BASE_MID  = 7'h03;
    localparam t_ofs OFS_COUNT_HI  = 7'h05;
    localparam t_ofs OFS_COUNT_MID = 7'h07;
    localparam t_ofs OFS_COUNT_LO  = 7'h09;
    localparam t_ofs OFS_SYNC      = 7'h0A;
    localparam t_ofs OFS_BASE_LO   = 7'h0D;
    localparam t_ofs OFS_REZ       = 7'h60;

    localparam t_colour COLOUR_MASK = 16'h0fff;
    localparam logic [7:0] SYNC_RESET = 8'h02;
    localparam t_rez REZ_LOW  = 2'd0;
    localparam t_rez REZ_MID  = 2'd1;
    localparam t_rez REZ_HIGH = 2'd2;

    localparam int IN_WIDTH  = 24;
    localparam int OUT_WIDTH = 48;

    function automatic t_colour f_boot_colour(input logic [3:0] idx);
        t_colour c;
        unique case (idx)
            4'd0:  c = 16'h0fff;
            4'd1:  c = 16'h0f00;
            4'd2:  c = 16'h00f0;
            4'd3:  c = 16'h0ff0;
            4'd4:  c = 16'h000f;
            4'd5:  c = 16'h0f0f;
            4'd6:  c = 16'h00ff;
            4'd7:  c = 16'h0555;
            4'd8:  c = 16'h0333;
            4'd9:  c = 16'h0f33;
            4'd10: c = 16'h03f3;
            4'd11: c = 16'h0ff3;
            4'd12: c = 16'h033f;
            4'd13: c = 16'h0f3f;
            4'd14: c = 16'h03ff;
            default: c = 16'h0000;
        endcase
        return c;
    endfunction

    function automatic logic f_is_palette(input t_ofs ofs);
        return ofs[6:5] == 2'b10;
    endfunction

    function automatic logic f_is_named(input t_ofs ofs);
        return ofs == OFS_BASE_HI || ofs == OFS_BASE_MID || ofs == OFS_BASE_LO ||
               ofs == OFS_COUNT_HI || ofs == OFS_COUNT_MID || ofs == OFS_COUNT_LO ||
               ofs == OFS_SYNC || ofs == OFS_REZ || f_is_palette(ofs);
    endfunction

endpackage

// ----- hdl/vsrf_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module vsrf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/video_shifter_register_file_core.sv -----
// Top level: byte-wide register window of a video shifter.
`timescale 1ns / 1ps

// One request is taken every cycle while the output is not stalled; it is held
// in the input stage register and its result is then loaded into the output
// register. The rate is set by a single input stage and the result register,
// with the scratch bytes held in a RAM that is read when the request is taken.
// Scratch writes land in the RAM at request time, other state is updated as the
// result is formed. Per-entry valid bits make never-written scratch bytes read
// as zero, so no clearing pass follows reset. Configuration writes are registered.
module video_shifter_register_file_core
    import vsrf_pkg::*;
#(
    parameter int REG_SPACE_BYTES = 128
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic                 i_cfg_index,
    input  logic [23:0]          i_cfg_data,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // [1:0] operation, [8:2] offset, [16:9] write_data
    input  logic [IN_WIDTH-1:0]  s_axis_tdata,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // [7:0] read_data, [8] palette_changed, [40:9] change_count, [41] mode_was_set
    output logic [OUT_WIDTH-1:0] m_axis_tdata
);

    localparam int AW = $clog2(REG_SPACE_BYTES);
    localparam logic [8:0] RegSpace = 9'(REG_SPACE_BYTES);

    logic [23:0] r_screen_start;
    logic [3:0]  r_plane_count;

    logic [23:0] r_screen_base, n_screen_base;
    t_rez        r_resolution, n_resolution;
    logic        r_rez_written, n_rez_written;
    logic [7:0]  r_sync, n_sync;
    t_colour     r_palette [16];
    t_colour     n_palette [16];
    logic [31:0] r_changes, n_changes;
    logic        r_powered, n_powered;
    logic [REG_SPACE_BYTES-1:0] r_scr_valid;

    logic [1:0]  r_s1_op;
    t_ofs        r_s1_ofs;
    logic [7:0]  r_s1_data;
    logic        r_s1_valid;
    logic        r_s1_scr_valid;

    logic                 r_out_valid;
    logic [OUT_WIDTH-1:0] r_out_data;

    logic        in_accept;
    logic        s1_advance;
    logic [1:0]  in_op;
    t_ofs        in_ofs;
    logic [7:0]  in_data;
    logic        in_space;
    logic [AW-1:0] in_addr;
    logic        scr_we;
    logic [7:0]  scr_rdata;

    logic        s1_space;
    logic [3:0]  pal_idx;
    t_colour     pal_old;
    t_colour     pal_masked;
    t_colour     pal_new;
    logic [7:0]  rd;
    logic        chg;
    t_rez        reinit_rez;

    assign in_op    = s_axis_tdata[1:0];
    assign in_ofs   = s_axis_tdata[8:2];
    assign in_data  = s_axis_tdata[16:9];
    assign in_space = {2'b00, in_ofs} < RegSpace;
    assign in_addr  = AW'(in_ofs);

    assign s1_advance    = r_s1_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_s1_valid || s1_advance;
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign scr_we        = in_accept && in_op == OP_WRITE && in_space && !f_is_named(in_ofs);

    vsrf_ram #(
        .WIDTH(8),
        .DEPTH(REG_SPACE_BYTES)
    ) u_scratch (
        .i_clk  (i_clk),
        .i_we   (scr_we),
        .i_waddr(in_addr),
        .i_wdata(in_data),
        .i_re   (in_accept),
        .i_raddr(in_addr),
        .o_rdata(scr_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_screen_start <= '0;
            r_plane_count  <= 4'd4;
        end else if (i_cfg_wr_en) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_SCREEN_START: r_screen_start <= i_cfg_data;
                CFG_PLANE_COUNT:  r_plane_count  <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scr_valid <= '0;
        end else if (scr_we) begin
            r_scr_valid[in_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_advance) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_op        <= in_op;
            r_s1_ofs       <= in_ofs;
            r_s1_data      <= in_data;
            r_s1_scr_valid <= in_space ? r_scr_valid[in_addr] : 1'b0;
        end
    end

    assign s1_space   = {2'b00, r_s1_ofs} < RegSpace;
    assign pal_idx    = r_s1_ofs[4:1];
    assign pal_old    = r_palette[pal_idx];
    assign pal_masked = pal_old & COLOUR_MASK;
    assign pal_new    = r_s1_ofs[0] ? {pal_old[15:8], r_s1_data}
                                    : {r_s1_data, pal_old[7:0]};
    assign reinit_rez = (r_plane_count >= 4'd4) ? REZ_LOW :
                        (r_plane_count == 4'd2) ? REZ_MID : REZ_HIGH;

    always_comb begin
        rd = '0;
        if (f_is_palette(r_s1_ofs)) begin
            rd = r_s1_ofs[0] ? pal_masked[7:0] : pal_masked[15:8];
        end else begin
            unique case (r_s1_ofs)
                OFS_BASE_HI, OFS_COUNT_HI:   rd = r_screen_base[23:16];
                OFS_BASE_MID, OFS_COUNT_MID: rd = r_screen_base[15:8];
                OFS_BASE_LO, OFS_COUNT_LO:   rd = r_screen_base[7:0];
                OFS_SYNC:                    rd = r_sync;
                OFS_REZ:                     rd = {6'd0, r_resolution};
                default: rd = (s1_space && r_s1_scr_valid) ? scr_rdata : 8'd0;
            endcase
        end
    end

    always_comb begin
        n_screen_base = r_screen_base;
        n_resolution  = r_resolution;
        n_rez_written = r_rez_written;
        n_sync        = r_sync;
        n_palette     = r_palette;
        n_changes     = r_changes;
        n_powered     = r_powered;
        chg           = 1'b0;
        unique case (t_op'(r_s1_op))
            OP_WRITE: begin
                if (f_is_palette(r_s1_ofs)) begin
                    if (pal_new != pal_old) begin
                        n_palette[pal_idx] = pal_new;
                        n_changes          = r_changes + 32'd1;
                        chg                = 1'b1;
                    end
                end else begin
                    unique case (r_s1_ofs)
                        OFS_BASE_HI:  n_screen_base = {r_s1_data, r_screen_base[15:8], 8'd0};
                        OFS_BASE_MID: n_screen_base = {r_screen_base[23:16], r_s1_data, 8'd0};
                        OFS_BASE_LO:  n_screen_base = {r_screen_base[23:8], r_s1_data[7:1],
                                                       1'b0};
                        OFS_SYNC:     n_sync = r_s1_data;
                        OFS_REZ: begin
                            n_resolution  = r_s1_data[1:0];
                            n_rez_written = 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
            OP_REINIT: begin
                n_screen_base = r_screen_start;
                n_resolution  = reinit_rez;
                n_rez_written = 1'b0;
                if (!r_powered) begin
                    n_powered = 1'b1;
                    for (int i = 0; i < 16; i++) begin
                        n_palette[i] = f_boot_colour(4'(i));
                    end
                    if (reinit_rez == REZ_MID) begin
                        n_palette[3] = f_boot_colour(4'd15);
                    end else if (reinit_rez == REZ_HIGH) begin
                        n_palette[1] = f_boot_colour(4'd15);
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_screen_base <= '0;
            r_resolution  <= REZ_LOW;
            r_rez_written <= 1'b0;
            r_sync        <= SYNC_RESET;
            r_changes     <= '0;
            r_powered     <= 1'b0;
            for (int i = 0; i < 16; i++) begin
                r_palette[i] <= f_boot_colour(4'(i));
            end
        end else if (s1_advance) begin
            r_screen_base <= n_screen_base;
            r_resolution  <= n_resolution;
            r_rez_written <= n_rez_written;
            r_sync        <= n_sync;
            r_changes     <= n_changes;
            r_powered     <= n_powered;
            r_palette     <= n_palette;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_advance) begin
            r_out_data <= {6'd0, n_rez_written, n_changes, chg,
                           (t_op'(r_s1_op) == OP_READ) ? rd : 8'd0};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule
